>>> hdl/size_tree_offset_translator_defines.svh
// ----------------------------------------------------------------------------
// Size tree offset translator: assertion macros
// Shared concurrent assertion forms, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef SIZE_TREE_OFFSET_TRANSLATOR_DEFINES_SVH
`define SIZE_TREE_OFFSET_TRANSLATOR_DEFINES_SVH

// same-cycle implication
`define STOT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stot check failed");

// next-cycle implication
`define STOT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stot check failed");

`endif

>>> hdl/stot_pkg.sv
// ----------------------------------------------------------------------------
// stot_pkg
// Types and constants of the size tree offset translator.
// ----------------------------------------------------------------------------
`default_nettype none
package stot_pkg;
	localparam int MaxBlocks = 1024;
	localparam int IdxW  = $clog2(MaxBlocks);
	localparam int CntW  = IdxW + 1;
	localparam int SumW  = 42;
	localparam int WordW = 32;
	localparam int RoffW = 33;

	typedef enum logic [2:0] {
		ACT_LOOKUP = 3'd0,
		ACT_READ   = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_RESIZE = 3'd3,
		ACT_DELETE = 3'd4,
		ACT_TOTALS = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OFF_RANGE = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LK_RD, S_LK_CHK, S_RB_RD, S_RB_GET, S_RS_RD, S_RS_UPD,
		S_SH_RD, S_SH_WR, S_INS_WR, S_DL_RD, S_DL_SZ, S_DL_END, S_FIN
	} state_t;
endpackage
`default_nettype wire

>>> hdl/stot_if.sv
// ----------------------------------------------------------------------------
// stot_req_if / stot_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface stot_req_if ();
	logic                       valid;
	logic                       ready;
	logic [2:0]                 action;
	logic [stot_pkg::CntW-1:0]  block_index;
	logic                       append;
	logic [stot_pkg::SumW-1:0]  virtual_offset;
	logic [stot_pkg::WordW-1:0] real_base;
	logic [stot_pkg::WordW-1:0] blk_len;
	modport source (output valid, action, block_index, append, virtual_offset, real_base,
		blk_len, input ready);
	modport sink (input valid, action, block_index, append, virtual_offset, real_base,
		blk_len, output ready);
endinterface

interface stot_rsp_if ();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [stot_pkg::IdxW-1:0]  found_index;
	logic [stot_pkg::RoffW-1:0] phys_offset;
	logic [stot_pkg::WordW-1:0] found_size;
	logic [stot_pkg::SumW-1:0]  total_size;
	logic [stot_pkg::CntW-1:0]  count_out;
	modport source (output valid, status, found_index, phys_offset, found_size, total_size,
		count_out, input ready);
	modport sink (input valid, status, found_index, phys_offset, found_size, total_size,
		count_out, output ready);
endinterface
`default_nettype wire

>>> hdl/stot_ram.sv
// ----------------------------------------------------------------------------
// stot_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stot_ram #(
	parameter int Width = 64,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hdl/size_tree_offset_translator.sv
// Lookup walks the list from block 0, reading one block and then comparing and
// adding its size before it moves on; insert and delete shift the entries
// after the position, one entry moved per read/write pair on the block RAM.
// One item at a time: ready only when idle.
// Reset: block count and total clear at once; block RAM content is left as is.
// ----------------------------------------------------------------------------
// size_tree_offset_translator
// Ordered list of variable-sized blocks with virtual-to-real offset lookup.
// ----------------------------------------------------------------------------
`default_nettype none
module size_tree_offset_translator (
	input wire logic   clk,
	input wire logic   arst_n,
	stot_req_if.sink   req,
	stot_rsp_if.source rsp
);
	localparam int IdxW = stot_pkg::IdxW;
	localparam int CntW = stot_pkg::CntW;
	localparam int SumW = stot_pkg::SumW;
	localparam int WW   = stot_pkg::WordW;
	localparam logic [CntW-1:0] MaxCnt = CntW'(stot_pkg::MaxBlocks);

	stot_pkg::state_t state_q, state_d;

	logic [2:0]      op_q;
	logic [CntW-1:0] bi_q, idx_q, cnt_q;
	logic [SumW-1:0] off_q, acc_q, total_q;
	logic [WW-1:0]   base_q, size_q;
	logic [1:0]      st_q;
	logic [IdxW-1:0] fidx_q;
	logic [stot_pkg::RoffW-1:0] roff_q;
	logic [WW-1:0]   fsz_q;
	logic            ov_q;

	logic            we;
	logic [IdxW-1:0] waddr, raddr;
	logic [2*WW-1:0] wdata, rdata;
	logic [WW-1:0]   rd_size, rd_base;
	logic [SumW-1:0] end_sum;
	logic            hit, accept, out_free;
	logic [CntW-1:0] pos;

	stot_ram #(.Width(2*WW), .Depth(stot_pkg::MaxBlocks)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign rd_size  = rdata[WW-1:0];
	assign rd_base  = rdata[2*WW-1:WW];
	assign end_sum  = acc_q + SumW'(rd_size);
	assign hit      = off_q < end_sum;
	assign accept   = req.valid && req.ready;
	assign out_free = !ov_q || rsp.ready;
	assign pos      = req.append ? cnt_q : req.block_index;
	assign req.ready = (state_q == stot_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stot_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = idx_q[IdxW-1:0];
		wdata   = rdata;
		raddr   = idx_q[IdxW-1:0];
		case (state_q)
			stot_pkg::S_IDLE: begin
				if (req.valid) begin
					case (req.action)
						stot_pkg::ACT_LOOKUP:
							state_d = (req.virtual_offset >= total_q) ? stot_pkg::S_FIN
								: stot_pkg::S_LK_RD;
						stot_pkg::ACT_READ:
							state_d = (req.block_index >= cnt_q) ? stot_pkg::S_FIN
								: stot_pkg::S_RB_RD;
						stot_pkg::ACT_RESIZE:
							state_d = (req.block_index >= cnt_q) ? stot_pkg::S_FIN
								: stot_pkg::S_RS_RD;
						stot_pkg::ACT_DELETE:
							state_d = (req.block_index >= cnt_q) ? stot_pkg::S_FIN
								: stot_pkg::S_DL_RD;
						stot_pkg::ACT_INSERT: begin
							if (cnt_q == MaxCnt || pos > cnt_q) begin
								state_d = stot_pkg::S_FIN;
							end else if (pos == cnt_q) begin
								state_d = stot_pkg::S_INS_WR;
							end else begin
								state_d = stot_pkg::S_SH_RD;
							end
						end
						default: state_d = stot_pkg::S_FIN;
					endcase
				end
			end
			stot_pkg::S_LK_RD:  state_d = stot_pkg::S_LK_CHK;
			stot_pkg::S_LK_CHK:
				state_d = (hit || idx_q + 1'b1 == cnt_q) ? stot_pkg::S_FIN : stot_pkg::S_LK_RD;
			stot_pkg::S_RB_RD:  state_d = stot_pkg::S_RB_GET;
			stot_pkg::S_RB_GET: state_d = stot_pkg::S_FIN;
			stot_pkg::S_RS_RD:  state_d = stot_pkg::S_RS_UPD;
			stot_pkg::S_RS_UPD: begin
				we      = 1'b1;
				wdata   = {rd_base, size_q};
				state_d = stot_pkg::S_FIN;
			end
			stot_pkg::S_SH_RD: begin
				// insert moves entries up, delete moves them down
				raddr = (op_q == stot_pkg::ACT_INSERT) ? IdxW'(idx_q - 1'b1)
					: IdxW'(idx_q + 1'b1);
				state_d = stot_pkg::S_SH_WR;
			end
			stot_pkg::S_SH_WR: begin
				we = 1'b1;
				if (op_q == stot_pkg::ACT_INSERT) begin
					state_d = (idx_q - 1'b1 == bi_q) ? stot_pkg::S_INS_WR : stot_pkg::S_SH_RD;
				end else begin
					state_d = (idx_q + 2'd2 == cnt_q) ? stot_pkg::S_DL_END : stot_pkg::S_SH_RD;
				end
			end
			stot_pkg::S_INS_WR: begin
				we      = 1'b1;
				waddr   = bi_q[IdxW-1:0];
				wdata   = {base_q, size_q};
				state_d = stot_pkg::S_FIN;
			end
			stot_pkg::S_DL_RD:  state_d = stot_pkg::S_DL_SZ;
			stot_pkg::S_DL_SZ:
				state_d = (idx_q + 1'b1 == cnt_q) ? stot_pkg::S_DL_END : stot_pkg::S_SH_RD;
			stot_pkg::S_DL_END: state_d = stot_pkg::S_FIN;
			stot_pkg::S_FIN:    if (out_free) state_d = stot_pkg::S_IDLE;
			default:            state_d = stot_pkg::S_IDLE;
		endcase
	end

	// block count, total and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (state_q == stot_pkg::S_INS_WR) begin
				cnt_q   <= cnt_q + 1'b1;
				total_q <= total_q + SumW'(size_q);
			end
			if (state_q == stot_pkg::S_RS_UPD) begin
				total_q <= total_q + SumW'(size_q) - SumW'(rd_size);
			end
			if (state_q == stot_pkg::S_DL_SZ) begin
				total_q <= total_q - SumW'(rd_size);
			end
			if (state_q == stot_pkg::S_DL_END) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == stot_pkg::S_FIN && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// operands and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.action;
			off_q  <= req.virtual_offset;
			base_q <= req.real_base;
			size_q <= req.blk_len;
			acc_q  <= '0;
			roff_q <= '0;
			fsz_q  <= '0;
			case (req.action)
				stot_pkg::ACT_LOOKUP: begin
					bi_q   <= req.block_index;
					idx_q  <= '0;
					fidx_q <= '0;
					st_q   <= (req.virtual_offset >= total_q) ? stot_pkg::ST_OFF_RANGE
						: stot_pkg::ST_OK;
				end
				stot_pkg::ACT_READ, stot_pkg::ACT_RESIZE, stot_pkg::ACT_DELETE: begin
					bi_q  <= req.block_index;
					idx_q <= req.block_index;
					if (req.block_index >= cnt_q) begin
						st_q   <= stot_pkg::ST_BAD_INDEX;
						fidx_q <= '0;
					end else begin
						st_q   <= stot_pkg::ST_OK;
						fidx_q <= req.block_index[IdxW-1:0];
					end
				end
				stot_pkg::ACT_INSERT: begin
					bi_q  <= pos;
					idx_q <= cnt_q;
					if (cnt_q == MaxCnt) begin
						st_q   <= stot_pkg::ST_FULL;
						fidx_q <= '0;
					end else if (pos > cnt_q) begin
						st_q   <= stot_pkg::ST_BAD_INDEX;
						fidx_q <= '0;
					end else begin
						st_q   <= stot_pkg::ST_OK;
						fidx_q <= pos[IdxW-1:0];
					end
				end
				default: begin
					bi_q   <= req.block_index;
					idx_q  <= req.block_index;
					st_q   <= stot_pkg::ST_OK;
					fidx_q <= '0;
				end
			endcase
		end
		case (state_q)
			stot_pkg::S_LK_CHK: begin
				if (hit) begin
					fidx_q <= idx_q[IdxW-1:0];
					fsz_q  <= rd_size;
					// distance into the block is below its size, so 32 bits suffice
					roff_q <= {1'b0, rd_base} + {1'b0, off_q[WW-1:0] - acc_q[WW-1:0]};
				end else begin
					acc_q <= end_sum;
					idx_q <= idx_q + 1'b1;
					if (idx_q + 1'b1 == cnt_q) st_q <= stot_pkg::ST_OFF_RANGE;
				end
			end
			stot_pkg::S_RB_GET: begin
				fsz_q  <= rd_size;
				roff_q <= {1'b0, rd_base};
			end
			stot_pkg::S_SH_WR: begin
				idx_q <= (op_q == stot_pkg::ACT_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == stot_pkg::S_FIN && out_free) begin
			rsp.status      <= st_q;
			rsp.found_index <= fidx_q;
			rsp.phys_offset <= roff_q;
			rsp.found_size  <= fsz_q;
			rsp.total_size  <= total_q;
			rsp.count_out   <= cnt_q;
		end
	end

	assign rsp.valid = ov_q;
endmodule
`default_nettype wire

>>> hdl/stot_checker.sv
// ----------------------------------------------------------------------------
// stot_checker
// Port-level checks on the translator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "size_tree_offset_translator_defines.svh"
module stot_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] status,
	input wire logic [stot_pkg::IdxW-1:0] found_index,
	input wire logic [stot_pkg::RoffW-1:0] phys_offset,
	input wire logic [stot_pkg::CntW-1:0] count_out
);
	localparam logic [stot_pkg::CntW-1:0] MaxCnt = stot_pkg::CntW'(stot_pkg::MaxBlocks);

	`STOT_ASSERT_NXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
	`STOT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`STOT_ASSERT_NOW(a_count_max, out_valid, count_out <= MaxCnt)
	`STOT_ASSERT_NOW(a_err_zero, out_valid && status != stot_pkg::ST_OK,
		found_index == '0 && phys_offset == '0)
	`STOT_ASSERT_NOW(a_full_count, out_valid && status == stot_pkg::ST_FULL,
		count_out == MaxCnt)
endmodule

bind size_tree_offset_translator stot_checker u_stot_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.status(rsp.status), .found_index(rsp.found_index),
	.phys_offset(rsp.phys_offset), .count_out(rsp.count_out)
);
`default_nettype wire

>>> tb/size_tree_offset_translator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_tree_offset_translator_tb
// Drives list edits, lookups and reads, tracks the block list in a local
// model and checks every result field against it, with random stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module size_tree_offset_translator_tb;
	localparam int MaxBlocks  = stot_pkg::MaxBlocks;
	localparam int IdxW       = stot_pkg::IdxW;
	localparam int CntW       = stot_pkg::CntW;
	localparam int SumW       = stot_pkg::SumW;
	localparam int WordW      = stot_pkg::WordW;
	localparam int RoffW      = stot_pkg::RoffW;
	localparam int IdleLimit  = 20000;
	localparam int TailCycles = 50;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	typedef struct packed {
		logic [1:0]       status;
		logic [IdxW-1:0]  found_index;
		logic [RoffW-1:0] phys_offset;
		logic [WordW-1:0] found_size;
		logic [SumW-1:0]  total_size;
		logic [CntW-1:0]  count_out;
	} translation_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	stot_req_if req_ch ();
	stot_rsp_if rsp_ch ();

	size_tree_offset_translator DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// local copy of the block list
	logic [WordW-1:0] blk_size [MaxBlocks];
	logic [WordW-1:0] blk_base [MaxBlocks];
	int               blk_count;

	translation_t expected_results[$];
	int           mismatches = 0;
	int           idle_cycles = 0;
	bit           no_idle;

	function automatic logic [SumW-1:0] list_total();
		logic [SumW-1:0] t;
		t = '0;
		for (int b = 0; b < blk_count; b++)
			t = t + SumW'(blk_size[b]);
		return t;
	endfunction

	function automatic translation_t predict_translation(logic [2:0] act, logic [10:0] idx,
			logic app, logic [SumW-1:0] voff, logic [WordW-1:0] rbase,
			logic [WordW-1:0] bsize);
		translation_t r;
		logic [SumW:0] acc;
		int pos;
		r = '0;
		case (act)
			stot_pkg::ACT_LOOKUP: begin
				r.status = stot_pkg::ST_OFF_RANGE;
				acc = '0;
				if (voff < list_total()) begin
					for (int b = 0; b < blk_count; b++) begin
						if (voff < acc + blk_size[b]) begin
							r.status = stot_pkg::ST_OK;
							r.found_index = IdxW'(b);
							r.found_size = blk_size[b];
							r.phys_offset = RoffW'(blk_base[b] + (voff - acc));
							break;
						end
						acc = acc + blk_size[b];
					end
				end
			end
			stot_pkg::ACT_READ: begin
				if (idx >= blk_count) r.status = stot_pkg::ST_BAD_INDEX;
				else begin
					r.found_index = idx[IdxW-1:0];
					r.phys_offset = RoffW'(blk_base[idx]);
					r.found_size = blk_size[idx];
				end
			end
			stot_pkg::ACT_INSERT: begin
				pos = app ? blk_count : int'(idx);
				if (blk_count >= MaxBlocks) r.status = stot_pkg::ST_FULL;
				else if (pos > blk_count) r.status = stot_pkg::ST_BAD_INDEX;
				else begin
					for (int b = blk_count; b > pos; b--) begin
						blk_size[b] = blk_size[b-1];
						blk_base[b] = blk_base[b-1];
					end
					blk_size[pos] = bsize;
					blk_base[pos] = rbase;
					blk_count++;
					r.found_index = IdxW'(pos);
				end
			end
			stot_pkg::ACT_RESIZE: begin
				if (idx >= blk_count) r.status = stot_pkg::ST_BAD_INDEX;
				else begin
					blk_size[idx] = bsize;
					r.found_index = idx[IdxW-1:0];
				end
			end
			stot_pkg::ACT_DELETE: begin
				if (idx >= blk_count) r.status = stot_pkg::ST_BAD_INDEX;
				else begin
					for (int b = int'(idx); b < blk_count - 1; b++) begin
						blk_size[b] = blk_size[b+1];
						blk_base[b] = blk_base[b+1];
					end
					blk_count--;
					r.found_index = idx[IdxW-1:0];
				end
			end
			default: ;
		endcase
		r.total_size = list_total();
		r.count_out = CntW'(blk_count);
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_request(logic [2:0] act, logic [10:0] idx, logic app,
			logic [SumW-1:0] voff, logic [WordW-1:0] rbase, logic [WordW-1:0] bsize);
		while (!no_idle && $urandom_range(99) < 11) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.action         <= act;
		req_ch.block_index    <= idx;
		req_ch.append         <= app;
		req_ch.virtual_offset <= voff;
		req_ch.real_base      <= rbase;
		req_ch.blk_len        <= bsize;
		do @(posedge clk); while (!req_ch.ready);
		expected_results.push_back(predict_translation(act, idx, app, voff, rbase, bsize));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (expected_results.size() != 0);
	endtask

	function automatic logic [WordW-1:0] pick_size();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom;
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	function automatic logic [SumW-1:0] pick_offset();
		logic [63:0] r;
		logic [SumW-1:0] t;
		t = list_total();
		r = {$urandom, $urandom};
		if (t != 0 && $urandom_range(3) != 0) return SumW'(r % t);
		return r[SumW-1:0];
	endfunction

	// result checker
	always @(posedge clk) begin
		translation_t got, exp_r;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.status, rsp_ch.found_index, rsp_ch.phys_offset,
				rsp_ch.found_size, rsp_ch.total_size, rsp_ch.count_out};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer: %p", got);
			end else begin
				exp_r = expected_results.pop_front();
				if (got.status !== exp_r.status || got.found_index !== exp_r.found_index ||
						got.phys_offset !== exp_r.phys_offset ||
						got.found_size !== exp_r.found_size ||
						got.total_size !== exp_r.total_size ||
						got.count_out !== exp_r.count_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, actual %p", exp_r, got);
				end
			end
		end
	end

	always @(negedge clk)
		rsp_ch.ready <= no_idle || ($urandom_range(99) >= 11);

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_empty_list();
		send_request(stot_pkg::ACT_LOOKUP, 0, 0, 0, 0, 0);
		send_request(stot_pkg::ACT_READ, 0, 0, 0, 0, 0);
		send_request(stot_pkg::ACT_RESIZE, 0, 0, 0, 0, 5);
		send_request(stot_pkg::ACT_DELETE, 0, 0, 0, 0, 0);
		send_request(stot_pkg::ACT_INSERT, 1, 0, 0, 0, 5);
		send_request(stot_pkg::ACT_TOTALS, 0, 0, 0, 0, 0);
		send_request(ACT_SPARE6, 11'h7FF, 1, '1, '1, '1);
		send_request(ACT_SPARE7, 0, 0, 0, 0, 0);
	endtask

	task automatic test_directed_edits();
		send_request(stot_pkg::ACT_INSERT, 0, 0, 0, 32'h1000, 100);
		send_request(stot_pkg::ACT_INSERT, 11'h7FF, 1, 0, '1, '1);
		send_request(stot_pkg::ACT_INSERT, 1, 0, 0, 32'h2000, 0);
		send_request(stot_pkg::ACT_INSERT, 0, 0, 0, 32'h3000, 7);
		send_request(stot_pkg::ACT_LOOKUP, 0, 0, 0, 0, 0);
		send_request(stot_pkg::ACT_LOOKUP, 0, 0, 7, 0, 0);
		send_request(stot_pkg::ACT_LOOKUP, 0, 0, list_total() - 1'b1, 0, 0);
		send_request(stot_pkg::ACT_LOOKUP, 0, 0, list_total(), 0, 0);
		send_request(stot_pkg::ACT_LOOKUP, 0, 0, '1, 0, 0);
		send_request(stot_pkg::ACT_READ, 3, 0, 0, 0, 0);
		send_request(stot_pkg::ACT_READ, 4, 0, 0, 0, 0);
		send_request(stot_pkg::ACT_RESIZE, 3, 0, 0, 0, 1);
		send_request(stot_pkg::ACT_RESIZE, 0, 0, 0, 0, '1);
		send_request(stot_pkg::ACT_LOOKUP, 0, 0, 32'hFFFF_FFFF, 0, 0);
		send_request(stot_pkg::ACT_DELETE, 1, 0, 0, 0, 0);
		send_request(stot_pkg::ACT_INSERT, 11'd1024, 0, 0, 0, 3);
		send_request(stot_pkg::ACT_TOTALS, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random_mix(int n_items);
		logic [2:0]  act;
		logic [10:0] idx;
		int          w;
		for (int i = 0; i < n_items; i++) begin
			no_idle = (i >= n_items / 3) && (i < n_items / 3 + 60);
			w = $urandom_range(99);
			if (w < 25) act = stot_pkg::ACT_INSERT;
			else if (w < 37) act = (blk_count > 40) ? stot_pkg::ACT_DELETE : stot_pkg::ACT_INSERT;
			else if (w < 45) act = stot_pkg::ACT_DELETE;
			else if (w < 72) act = stot_pkg::ACT_LOOKUP;
			else if (w < 83) act = stot_pkg::ACT_READ;
			else if (w < 94) act = stot_pkg::ACT_RESIZE;
			else act = 3'($urandom_range(5, 7));
			if ($urandom_range(9) == 0) idx = 11'($urandom);
			else idx = 11'($urandom_range(0, blk_count));
			if (i == n_items / 2) wait_drained();
			send_request(act, idx, $urandom_range(3) == 0, pick_offset(), $urandom,
				pick_size());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		blk_count = 0;
		no_idle = 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.action         <= '0;
		req_ch.block_index    <= '0;
		req_ch.append         <= 1'b0;
		req_ch.virtual_offset <= '0;
		req_ch.real_base      <= '0;
		req_ch.blk_len        <= '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_list();
		test_directed_edits();
		test_random_mix(270);
		wait_drained();
		repeat (TailCycles) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
